// ----- rtl/pid_speed_controller_assert.svh -----
// Assertion macros for the PID speed controller.
// Used by the top level; no dependencies.
`ifndef PID_SPEED_CONTROLLER_ASSERT_SVH
`define PID_SPEED_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PIDSC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pidsc: same-cycle check failed");

// next-cycle implication
`define PIDSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pidsc: next-cycle check failed");

`endif

// ----- rtl/pidsc_pkg.sv -----
// Package for the PID speed controller: widths, register indexes, shared types.
// No dependencies.
package pidsc_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int SPEED_BITS     = 16;

    localparam int GAIN_W      = 16;
    localparam int WINDOW_W    = 16;
    localparam int INTEG_W     = 24;
    localparam int CMD_W       = 8;
    localparam int DRIVE_LIMIT = 127;

    localparam int ERR_W   = SPEED_BITS + 1;
    localparam int DERIV_W = ERR_W + 1;
    localparam int SUM_W   = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
    localparam int MAG_W   = (ERR_W > WINDOW_W) ? ERR_W : WINDOW_W;

    localparam int PROD_E_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + INTEG_W;
    localparam int PROD_D_W = GAIN_W + DERIV_W;
    localparam int PROD_MAX_W = (PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W;
    localparam int ACC_W    = PROD_MAX_W + 2;
    localparam int QUOT_W   = ACC_W - GAIN_FRAC_BITS;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = (SPEED_BITS > GAIN_W) ? SPEED_BITS : GAIN_W;
    localparam int S_TDATA_W  = ((SPEED_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((CMD_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOOP_ENABLE     = 3'd0,
        REG_TARGET_SPEED    = 3'd1,
        REG_GAIN_P          = 3'd2,
        REG_GAIN_I          = 3'd3,
        REG_GAIN_D          = 3'd4,
        REG_INTEGRAL_WINDOW = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                         loop_enable;
        logic signed [SPEED_BITS-1:0] target_speed;
        logic signed [GAIN_W-1:0]     gain_p;
        logic signed [GAIN_W-1:0]     gain_i;
        logic signed [GAIN_W-1:0]     gain_d;
        logic        [WINDOW_W-1:0]   integral_window;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        loop_enable:     1'b1,
        target_speed:    SPEED_BITS'(47),
        gain_p:          GAIN_W'(8192),
        gain_i:          GAIN_W'(164),
        gain_d:          GAIN_W'(0),
        integral_window: WINDOW_W'(50)
    };

    // error-stage result handed to the multiply pipeline
    typedef struct packed {
        logic                      valid;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } stage_t;

endpackage

// ----- rtl/pid_speed_controller.sv -----
// PID speed controller with integral window: top level.
// Depends on pidsc_pkg, pidsc_cfg_regs, pidsc_err_stage, pidsc_mac and
// pid_speed_controller_assert.svh.
//
// Usage:
//   s_ channel: one measured speed sample per transfer (s_tdata[15:0], signed).
//   m_ channel: one result per sample; m_tdata[7:0] is the signed motor
//   command (-127..127), m_tuser[0] flags that the drive was clamped.
//   cfg port: cfg_we/cfg_addr/cfg_wdata write one of six registers per cycle
//   (0 enable, 1 target, 2..4 gains P/I/D in Q.12, 5 integral window);
//   write only while no sample is in flight.
// Timing:
//   Five-stage pipeline (input, error/integral, multiply, accumulate, result).
//   One sample is accepted every cycle while the output is not stalled.
//   Only the error/integral stage carries loop state, and it is updated
//   in time for the next sample.
// Reset: pipeline empty, loop state cleared, registers at defaults.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready follows, so no transfer is lost.
module pid_speed_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // slave stream: measured_speed
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pidsc_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] measured_speed
    // master stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pidsc_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] motor_command
    output logic [0:0]                         m_tuser,   // [0] drive_clamped
    // configuration
    input  logic                               cfg_we,
    input  logic [pidsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pidsc_pkg::*;

    cfg_t               cfg;
    stage_t             s1;
    logic               advance;
    logic               out_valid;
    logic [CMD_W-1:0]   motor_command;
    logic               drive_clamped;

    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;

    pidsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidsc_err_stage u_err (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .s1       (s1)
    );

    pidsc_mac u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .cfg           (cfg),
        .s1            (s1),
        .out_valid     (out_valid),
        .motor_command (motor_command),
        .drive_clamped (drive_clamped)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'(motor_command);
    assign m_tuser  = drive_clamped;

    `include "pid_speed_controller_assert.svh"

    `PIDSC_ASSERT_NEXT(a_stage_hold, aclk, aresetn, !advance, $stable(s1))
    `PIDSC_ASSERT_IMPL(a_cmd_range, aclk, aresetn, m_tvalid, m_tdata != 8'h80)
    `PIDSC_ASSERT_IMPL(a_clamp_at_limit, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 8'h81 || m_tdata == 8'h7F)

endmodule

// ----- rtl/pidsc_cfg_regs.sv -----
// Configuration register file for the PID speed controller.
// Depends on pidsc_pkg.
module pidsc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pidsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pidsc_pkg::cfg_t                     cfg
);
    import pidsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_LOOP_ENABLE:     cfg_reg.loop_enable     <= cfg_wdata[0];
                REG_TARGET_SPEED:    cfg_reg.target_speed    <= $signed(cfg_wdata[SPEED_BITS-1:0]);
                REG_GAIN_P:          cfg_reg.gain_p          <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_I:          cfg_reg.gain_i          <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_D:          cfg_reg.gain_d          <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_INTEGRAL_WINDOW: cfg_reg.integral_window <= cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/pidsc_err_stage.sv -----
// Input register, error / windowed saturating integral / derivative, loop state.
// Depends on pidsc_pkg.
module pidsc_err_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              s_tvalid,
    input  logic [pidsc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  pidsc_pkg::cfg_t                   cfg,
    output pidsc_pkg::stage_t                 s1
);
    import pidsc_pkg::*;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic                         in_valid_reg;
    logic signed [SPEED_BITS-1:0] meas_reg;
    logic signed [ERR_W-1:0]      prev_err_reg, prev_err_next;
    logic signed [INTEG_W-1:0]    integ_reg, integ_next;
    stage_t                       s1_reg, s1_next;

    logic signed [ERR_W-1:0]   err_c;
    logic        [ERR_W-1:0]   mag_c;
    logic signed [SUM_W-1:0]   sum_c;
    logic signed [INTEG_W-1:0] sat_c;
    logic signed [DERIV_W-1:0] deriv_c;
    logic                      in_window;

    always_comb begin
        err_c   = ERR_W'(cfg.target_speed) - ERR_W'(meas_reg);
        mag_c   = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
        in_window = (MAG_W'(mag_c) < MAG_W'(cfg.integral_window)) && (cfg.gain_i != '0);
        sum_c   = SUM_W'(integ_reg) + SUM_W'(err_c);
        priority if (sum_c > SUM_W'(INTEG_MAX)) begin
            sat_c = INTEG_MAX;
        end else if (sum_c < SUM_W'(INTEG_MIN)) begin
            sat_c = INTEG_MIN;
        end else begin
            sat_c = INTEG_W'(sum_c);
        end
        deriv_c = DERIV_W'(err_c) - DERIV_W'(prev_err_reg);

        if (cfg.loop_enable) begin
            integ_next    = in_window ? sat_c : '0;
            prev_err_next = err_c;
            s1_next.err   = err_c;
            s1_next.deriv = deriv_c;
        end else begin
            integ_next    = '0;
            prev_err_next = '0;
            s1_next.err   = '0;
            s1_next.deriv = '0;
        end
        s1_next.integ = integ_next;
        s1_next.valid = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            s1_reg.valid <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
            s1_reg       <= s1_next;
            if (in_valid_reg) begin
                prev_err_reg <= prev_err_next;
                integ_reg    <= integ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            meas_reg <= $signed(s_tdata[SPEED_BITS-1:0]);
        end
    end

    assign s1 = s1_reg;

endmodule

// ----- rtl/pidsc_mac.sv -----
// Gain multiply, accumulate, truncating Q-format scale, clamp and negate; result register.
// Depends on pidsc_pkg.
module pidsc_mac (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  pidsc_pkg::cfg_t            cfg,
    input  pidsc_pkg::stage_t          s1,
    output logic                       out_valid,
    output logic [pidsc_pkg::CMD_W-1:0] motor_command,
    output logic                       drive_clamped
);
    import pidsc_pkg::*;

    localparam logic signed [QUOT_W-1:0] LIM_HI = QUOT_W'(DRIVE_LIMIT);
    localparam logic signed [QUOT_W-1:0] LIM_LO = -QUOT_W'(DRIVE_LIMIT);

    logic                       v2_reg, v3_reg, out_valid_reg;
    logic signed [PROD_E_W-1:0] prod_p_reg, prod_p_next;
    logic signed [PROD_I_W-1:0] prod_i_reg, prod_i_next;
    logic signed [PROD_D_W-1:0] prod_d_reg, prod_d_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic        [CMD_W-1:0]    cmd_reg, cmd_next;
    logic                       clamp_reg, clamp_next;

    logic signed [QUOT_W-1:0] quot_c, drive_c;
    logic                     round_up;

    always_comb begin
        prod_p_next = PROD_E_W'(cfg.gain_p) * PROD_E_W'(s1.err);
        prod_i_next = PROD_I_W'(cfg.gain_i) * PROD_I_W'(s1.integ);
        prod_d_next = PROD_D_W'(cfg.gain_d) * PROD_D_W'(s1.deriv);
        acc_next    = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);

        // floor shift, then bump negatives with a nonzero remainder: toward zero
        quot_c   = QUOT_W'(acc_reg >>> GAIN_FRAC_BITS);
        round_up = acc_reg[ACC_W-1] && (acc_reg[GAIN_FRAC_BITS-1:0] != '0);
        drive_c  = quot_c + $signed({{(QUOT_W-1){1'b0}}, round_up});
        priority if (drive_c > LIM_HI) begin
            cmd_next   = CMD_W'(-LIM_HI);
            clamp_next = 1'b1;
        end else if (drive_c < LIM_LO) begin
            cmd_next   = CMD_W'(-LIM_LO);
            clamp_next = 1'b1;
        end else begin
            cmd_next   = CMD_W'(-drive_c);
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v2_reg        <= s1.valid;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
            acc_reg    <= acc_next;
            cmd_reg    <= cmd_next;
            clamp_reg  <= clamp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_command = cmd_reg;
    assign drive_clamped = clamp_reg;

endmodule
